>>> design/cle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_pkg: shared codes and interface types
// Operation and status codes plus the command and status groups between
// the controller and the datapath of the circular list engine.
// ----------------------------------------------------------------------------
package cle_pkg;

	localparam logic [4:0] OP_ADD_FRONT = 5'd0;
	localparam logic [4:0] OP_ADD_BACK  = 5'd1;
	localparam logic [4:0] OP_ADD_AT    = 5'd2;
	localparam logic [4:0] OP_DEL_FRONT = 5'd3;
	localparam logic [4:0] OP_DEL_BACK  = 5'd4;
	localparam logic [4:0] OP_DEL_AT    = 5'd5;
	localparam logic [4:0] OP_RD_FRONT  = 5'd6;
	localparam logic [4:0] OP_RD_BACK   = 5'd7;
	localparam logic [4:0] OP_RD_AT     = 5'd8;
	localparam logic [4:0] OP_UPDATE    = 5'd9;
	localparam logic [4:0] OP_FIND      = 5'd10;
	localparam logic [4:0] OP_MIN       = 5'd11;
	localparam logic [4:0] OP_MAX       = 5'd12;
	localparam logic [4:0] OP_SIZE      = 5'd13;
	localparam logic [4:0] OP_TO_FRONT  = 5'd14;
	localparam logic [4:0] OP_TO_BACK   = 5'd15;
	localparam logic [4:0] OP_CLEAR     = 5'd16;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_EMPTY    = 3'd1;
	localparam logic [2:0] ST_NOTFOUND = 3'd2;
	localparam logic [2:0] ST_NOACTION = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	// node memory read address select
	localparam logic [1:0] RD_CUR  = 2'd0;
	localparam logic [1:0] RD_HEAD = 2'd1;
	localparam logic [1:0] RD_FREE = 2'd2;

	// scan compare mode
	localparam logic [1:0] SCAN_FIND = 2'd0;
	localparam logic [1:0] SCAN_MIN  = 2'd1;
	localparam logic [1:0] SCAN_MAX  = 2'd2;

	typedef struct packed {
		logic       load;      // capture position and value
		logic       dec;       // start of an operation
		logic       set_st;
		logic [2:0] st_code;
		logic [1:0] rd_sel;
		logic       step;      // advance cursor to next node
		logic       cur_prv;   // cursor to previous node
		logic       tk_val;    // take read value as result
		logic       scan;
		logic [1:0] scan_mode;
		logic       unl;       // unlink cursor node
		logic       rm;        // head and count update for removal
		logic       push;      // return cursor node to free chain
		logic       fh_pop;
		logic       ins_val;
		logic       ins_self;
		logic       lk_ins;    // link operands: new node before cursor
		logic       lk_a;
		logic       lk_b;
		logic       cnt_inc;
		logic       head_new;
		logic       head_nxt;
		logic       head_cur;
		logic       upd;
		logic       clr;
	} cle_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic inrange;
		logic pos_zero;
		logic at_pos;
		logic scan_end;
		logic hit;
	} cle_stat_t;

endpackage

>>> design/cle_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_ctrl: operation sequencer
// Decodes each operation and steps the datapath through link walks,
// scans, inserts, removals and moves, one node memory access a cycle.
// ----------------------------------------------------------------------------
module cle_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [4:0]          operation,
	input  cle_pkg::cle_stat_t  st,
	output cle_pkg::cle_cmd_t   cmd,
	output logic                busy,
	output logic                done
);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_DEC   = 5'd1;
	localparam logic [4:0] S_WALK  = 5'd2;
	localparam logic [4:0] S_WFET  = 5'd3;
	localparam logic [4:0] S_WSTEP = 5'd4;
	localparam logic [4:0] S_TF    = 5'd5;
	localparam logic [4:0] S_TV    = 5'd6;
	localparam logic [4:0] S_TAILF = 5'd7;
	localparam logic [4:0] S_TAILL = 5'd8;
	localparam logic [4:0] S_RMF   = 5'd9;
	localparam logic [4:0] S_RMW   = 5'd10;
	localparam logic [4:0] S_RMP   = 5'd11;
	localparam logic [4:0] S_INSAF = 5'd12;
	localparam logic [4:0] S_INSF  = 5'd13;
	localparam logic [4:0] S_INSA  = 5'd14;
	localparam logic [4:0] S_INSB  = 5'd15;
	localparam logic [4:0] S_UPD   = 5'd16;
	localparam logic [4:0] S_MVF   = 5'd17;
	localparam logic [4:0] S_MVU   = 5'd18;
	localparam logic [4:0] S_MVHF  = 5'd19;
	localparam logic [4:0] S_MVL1  = 5'd20;
	localparam logic [4:0] S_MVL2  = 5'd21;
	localparam logic [4:0] S_SCT   = 5'd22;
	localparam logic [4:0] S_SCF   = 5'd23;
	localparam logic [4:0] S_SCC   = 5'd24;

	logic [4:0] state_q;
	logic [4:0] nxt;
	logic [4:0] op_q;
	logic       done_q;
	logic       fin;

	always_comb begin
		cmd = '0;
		cmd.rd_sel = cle_pkg::RD_CUR;
		cmd.st_code = cle_pkg::ST_OK;
		nxt = state_q;
		fin = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					nxt = S_DEC;
				end
			end
			S_DEC: begin
				cmd.dec = 1'b1;
				cmd.set_st = 1'b1;
				if (op_q > cle_pkg::OP_CLEAR) begin
					cmd.st_code = cle_pkg::ST_NOACTION;
					fin = 1'b1;
				end else if (op_q == cle_pkg::OP_ADD_FRONT ||
					op_q == cle_pkg::OP_ADD_BACK) begin
					if (st.full) begin
						cmd.st_code = cle_pkg::ST_FULL;
						fin = 1'b1;
					end else begin
						nxt = S_INSAF;
					end
				end else if (st.empty) begin
					cmd.st_code = cle_pkg::ST_EMPTY;
					fin = 1'b1;
				end else begin
					case (op_q)
						cle_pkg::OP_ADD_AT: begin
							if (!st.inrange) begin
								cmd.st_code = cle_pkg::ST_NOTFOUND;
								fin = 1'b1;
							end else if (st.full) begin
								cmd.st_code = cle_pkg::ST_FULL;
								fin = 1'b1;
							end else begin
								nxt = S_WALK;
							end
						end
						cle_pkg::OP_DEL_FRONT: nxt = S_RMF;
						cle_pkg::OP_DEL_BACK: nxt = S_TAILF;
						cle_pkg::OP_RD_FRONT: nxt = S_TF;
						cle_pkg::OP_RD_BACK: nxt = S_TAILF;
						cle_pkg::OP_DEL_AT, cle_pkg::OP_RD_AT, cle_pkg::OP_UPDATE,
						cle_pkg::OP_TO_BACK: begin
							if (!st.inrange) begin
								cmd.st_code = cle_pkg::ST_NOTFOUND;
								fin = 1'b1;
							end else begin
								nxt = S_WALK;
							end
						end
						cle_pkg::OP_TO_FRONT: begin
							if (!st.inrange) begin
								cmd.st_code = cle_pkg::ST_NOTFOUND;
								fin = 1'b1;
							end else if (st.pos_zero) begin
								cmd.st_code = cle_pkg::ST_NOACTION;
								fin = 1'b1;
							end else begin
								nxt = S_WALK;
							end
						end
						cle_pkg::OP_FIND: begin
							cmd.st_code = cle_pkg::ST_NOTFOUND;
							nxt = S_SCT;
						end
						cle_pkg::OP_MIN, cle_pkg::OP_MAX: nxt = S_SCT;
						cle_pkg::OP_CLEAR: begin
							cmd.clr = 1'b1;
							fin = 1'b1;
						end
						default: fin = 1'b1;
					endcase
				end
			end
			S_WALK: begin
				if (st.at_pos) begin
					case (op_q)
						cle_pkg::OP_ADD_AT: nxt = S_INSAF;
						cle_pkg::OP_DEL_AT: nxt = S_RMF;
						cle_pkg::OP_RD_AT: nxt = S_TF;
						cle_pkg::OP_UPDATE: nxt = S_UPD;
						default: nxt = S_MVF;
					endcase
				end else begin
					nxt = S_WFET;
				end
			end
			S_WFET: nxt = S_WSTEP;
			S_WSTEP: begin
				cmd.step = 1'b1;
				nxt = S_WALK;
			end
			S_TF: nxt = S_TV;
			S_TV: begin
				cmd.tk_val = 1'b1;
				fin = 1'b1;
			end
			S_TAILF: nxt = S_TAILL;
			S_TAILL: begin
				cmd.cur_prv = 1'b1;
				nxt = (op_q == cle_pkg::OP_DEL_BACK) ? S_RMF : S_TF;
			end
			S_RMF: nxt = S_RMW;
			S_RMW: begin
				cmd.unl = 1'b1;
				cmd.rm = 1'b1;
				nxt = S_RMP;
			end
			S_RMP: begin
				cmd.push = 1'b1;
				fin = 1'b1;
			end
			S_INSAF: begin
				cmd.rd_sel = cle_pkg::RD_FREE;
				nxt = S_INSF;
			end
			S_INSF: begin
				cmd.fh_pop = 1'b1;
				nxt = S_INSA;
			end
			S_INSA: begin
				cmd.ins_val = 1'b1;
				cmd.lk_ins = 1'b1;
				if (st.empty) begin
					cmd.ins_self = 1'b1;
					cmd.head_new = 1'b1;
					cmd.cnt_inc = 1'b1;
					fin = 1'b1;
				end else begin
					cmd.lk_a = 1'b1;
					nxt = S_INSB;
				end
			end
			S_INSB: begin
				cmd.lk_ins = 1'b1;
				cmd.lk_b = 1'b1;
				cmd.cnt_inc = 1'b1;
				cmd.head_new = (op_q == cle_pkg::OP_ADD_FRONT) ||
					(op_q == cle_pkg::OP_ADD_AT && st.pos_zero);
				fin = 1'b1;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				fin = 1'b1;
			end
			S_MVF: nxt = S_MVU;
			S_MVU: begin
				if (op_q == cle_pkg::OP_TO_BACK && st.pos_zero) begin
					// rotate: head moves on to the next node
					cmd.head_nxt = 1'b1;
					fin = 1'b1;
				end else begin
					cmd.unl = 1'b1;
					nxt = S_MVHF;
				end
			end
			S_MVHF: begin
				cmd.rd_sel = cle_pkg::RD_HEAD;
				nxt = S_MVL1;
			end
			S_MVL1: begin
				cmd.lk_a = 1'b1;
				nxt = S_MVL2;
			end
			S_MVL2: begin
				cmd.lk_b = 1'b1;
				cmd.head_cur = (op_q == cle_pkg::OP_TO_FRONT);
				fin = 1'b1;
			end
			S_SCT: begin
				if (st.scan_end) begin
					fin = 1'b1;
				end else begin
					nxt = S_SCF;
				end
			end
			S_SCF: nxt = S_SCC;
			S_SCC: begin
				cmd.scan = 1'b1;
				case (op_q)
					cle_pkg::OP_MIN: cmd.scan_mode = cle_pkg::SCAN_MIN;
					cle_pkg::OP_MAX: cmd.scan_mode = cle_pkg::SCAN_MAX;
					default: cmd.scan_mode = cle_pkg::SCAN_FIND;
				endcase
				if (op_q == cle_pkg::OP_FIND && st.hit) begin
					fin = 1'b1;
				end else begin
					nxt = S_SCT;
				end
			end
			default: nxt = S_IDLE;
		endcase
		if (fin) begin
			nxt = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
			op_q <= cle_pkg::OP_ADD_FRONT;
		end else begin
			state_q <= nxt;
			done_q <= fin;
			if (cmd.load) begin
				op_q <= operation;
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

>>> design/cle_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_dpath: node memory and list registers
// Value, next and prev memories with one shared read address and registered read data,
// head, count, fill mark, free chain and the result registers.
// ----------------------------------------------------------------------------
module cle_dpath #(
	parameter int CAPACITY    = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cle_pkg::cle_cmd_t         cmd,
	input  logic [5:0]                position,
	input  logic signed [31:0]        value,
	output cle_pkg::cle_stat_t        st,
	output logic [2:0]                status,
	output logic signed [31:0]        value_out,
	output logic [5:0]                position_out,
	output logic [6:0]                count_out
);

	localparam int SW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > 6) ? CW : 6;

	logic signed [VALUE_WIDTH-1:0] vmem [CAPACITY];
	logic [SW-1:0]                 nmem [CAPACITY];
	logic [SW-1:0]                 pmem [CAPACITY];

	logic signed [VALUE_WIDTH-1:0] vrd_q;
	logic [SW-1:0]                 nrd_q;
	logic [SW-1:0]                 prd_q;

	logic [5:0]                    pos_q;
	logic signed [VALUE_WIDTH-1:0] val_q;
	logic signed [VALUE_WIDTH-1:0] best_q;
	logic [SW-1:0]                 cur_q;
	logic [CW-1:0]                 idx_q;
	logic [SW-1:0]                 head_q;
	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 fill_q;
	logic [SW-1:0]                 fhead_q;
	logic [SW-1:0]                 new_q;
	logic                          pop_q;
	logic [2:0]                    status_q;
	logic signed [31:0]            vout_q;
	logic [5:0]                    pout_q;

	logic [SW-1:0] rd_addr;
	logic [SW-1:0] node;
	logic [SW-1:0] succ;
	logic          gt1;
	logic          take;
	logic [XW-1:0] pos_x;
	logic [XW-1:0] cnt_x;
	logic [XW-1:0] idx_x;

	logic                          n_we;
	logic [SW-1:0]                 n_wa;
	logic [SW-1:0]                 n_wd;
	logic                          p_we;
	logic [SW-1:0]                 p_wa;
	logic [SW-1:0]                 p_wd;
	logic                          v_we;
	logic [SW-1:0]                 v_wa;

	assign pos_x = XW'(pos_q);
	assign cnt_x = XW'(count_q);
	assign idx_x = XW'(idx_q);
	assign gt1 = (count_q > CW'(1));

	assign st.empty = (count_q == '0);
	assign st.full = (count_q == CW'(CAPACITY));
	assign st.inrange = (pos_x < cnt_x);
	assign st.pos_zero = (pos_q == '0);
	assign st.at_pos = (idx_x == pos_x);
	assign st.scan_end = (idx_q == count_q);
	assign st.hit = (vrd_q == val_q);

	always_comb begin
		case (cmd.rd_sel)
			cle_pkg::RD_HEAD: rd_addr = head_q;
			cle_pkg::RD_FREE: rd_addr = fhead_q;
			default: rd_addr = cur_q;
		endcase
	end

	// link operands: a fresh node goes before the cursor, a moved node before head
	assign node = cmd.lk_ins ? new_q : cur_q;
	assign succ = cmd.lk_ins ? cur_q : head_q;

	always_comb begin
		n_we = 1'b1;
		n_wa = new_q;
		n_wd = new_q;
		if (cmd.ins_self) begin
			n_wa = new_q;
			n_wd = new_q;
		end else if (cmd.lk_a) begin
			n_wa = prd_q;
			n_wd = node;
		end else if (cmd.lk_b) begin
			n_wa = node;
			n_wd = succ;
		end else if (cmd.unl && gt1) begin
			n_wa = prd_q;
			n_wd = nrd_q;
		end else if (cmd.push) begin
			n_wa = cur_q;
			n_wd = fhead_q;
		end else begin
			n_we = 1'b0;
		end
	end

	always_comb begin
		p_we = 1'b1;
		p_wa = new_q;
		p_wd = new_q;
		if (cmd.ins_self) begin
			p_wa = new_q;
			p_wd = new_q;
		end else if (cmd.lk_a) begin
			p_wa = node;
			p_wd = prd_q;
		end else if (cmd.lk_b) begin
			p_wa = succ;
			p_wd = node;
		end else if (cmd.unl && gt1) begin
			p_wa = nrd_q;
			p_wd = prd_q;
		end else begin
			p_we = 1'b0;
		end
	end

	assign v_we = cmd.ins_val || cmd.upd;
	assign v_wa = cmd.ins_val ? new_q : cur_q;

	always_ff @(posedge clk) begin
		if (v_we) begin
			vmem[v_wa] <= val_q;
		end
		if (n_we) begin
			nmem[n_wa] <= n_wd;
		end
		if (p_we) begin
			pmem[p_wa] <= p_wd;
		end
		vrd_q <= vmem[rd_addr];
		nrd_q <= nmem[rd_addr];
		prd_q <= pmem[rd_addr];
	end

	always_comb begin
		case (cmd.scan_mode)
			cle_pkg::SCAN_MIN: take = (idx_q == '0) || (vrd_q < best_q);
			cle_pkg::SCAN_MAX: take = (idx_q == '0) || (best_q < vrd_q);
			default: take = st.hit;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
			fill_q <= '0;
		end else if (cmd.clr) begin
			head_q <= '0;
			count_q <= '0;
			fill_q <= '0;
		end else begin
			if (cmd.head_new) begin
				head_q <= new_q;
			end else if (cmd.rm) begin
				if (!gt1) begin
					head_q <= '0;
				end else if (cur_q == head_q) begin
					head_q <= nrd_q;
				end
			end else if (cmd.head_nxt) begin
				head_q <= nrd_q;
			end else if (cmd.head_cur) begin
				head_q <= cur_q;
			end
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.rm) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.ins_val && !pop_q) begin
				fill_q <= fill_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q <= position;
			val_q <= VALUE_WIDTH'(value);
		end
		if (cmd.dec) begin
			cur_q <= head_q;
			idx_q <= '0;
			vout_q <= '0;
			pout_q <= '0;
			// reuse a freed slot while the free chain holds any
			pop_q <= (fill_q != count_q);
			new_q <= (fill_q != count_q) ? fhead_q : fill_q[SW-1:0];
		end
		if (cmd.set_st) begin
			status_q <= cmd.st_code;
		end
		if (cmd.step || cmd.scan) begin
			cur_q <= nrd_q;
			idx_q <= idx_q + CW'(1);
		end
		if (cmd.cur_prv) begin
			cur_q <= prd_q;
		end
		if (cmd.tk_val) begin
			vout_q <= 32'(vrd_q);
		end
		if (cmd.scan && take) begin
			vout_q <= 32'(vrd_q);
			pout_q <= 6'(idx_q);
			best_q <= vrd_q;
			if (cmd.scan_mode == cle_pkg::SCAN_FIND) begin
				status_q <= cle_pkg::ST_OK;
			end
		end
		if (cmd.fh_pop && pop_q) begin
			fhead_q <= nrd_q;
		end
		if (cmd.push) begin
			fhead_q <= cur_q;
		end
	end

	assign status = status_q;
	assign value_out = vout_q;
	assign position_out = pout_q;
	assign count_out = 7'(count_q);

endmodule

>>> design/circular_list_engine_core.sv
`timescale 1ns / 1ps
// One operation at a time; busy stays high until done strobes. Every link hop
//   goes through the single shared read port of the node memory.
// Reset empties the list at once: head, count and fill mark clear, node memory
//   is not swept. The receiver cannot stall; done is high for one cycle per result.
// ----------------------------------------------------------------------------
// circular_list_engine_core: bounded circular doubly linked list
// Sequencer and node memory datapath for list add, delete, read, update,
// search, move and clear operations.
// ----------------------------------------------------------------------------
module circular_list_engine_core #(
	parameter int CAPACITY    = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [4:0]         operation,
	input  logic [5:0]         position,
	input  logic signed [31:0] value,
	output logic               busy,
	output logic               done,
	output logic [2:0]         status,
	output logic signed [31:0] value_out,
	output logic [5:0]         position_out,
	output logic [6:0]         count_out
);

	cle_pkg::cle_cmd_t  cmd;
	cle_pkg::cle_stat_t st;

	cle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.st        (st),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

	cle_dpath #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.position     (position),
		.value        (value),
		.st           (st),
		.status       (status),
		.value_out    (value_out),
		.position_out (position_out),
		.count_out    (count_out)
	);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while an operation is still running");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transfer did not start an operation");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == cle_pkg::ST_FULL) |-> count_out == 7'(CAPACITY))
		else $error("full reported below capacity");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == cle_pkg::ST_EMPTY) |-> count_out == 7'd0)
		else $error("empty reported with entries present");

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for circular_list_engine_core
// Drives list commands through the start/busy handshake, tracks the list
// contents as an ordered queue of values and checks every done strobe
// field by field against the predicted status, value, position and count.
// ----------------------------------------------------------------------------
module tb;

	localparam int LIST_DEPTH  = 64;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] value;
		logic [5:0]         position;
		logic [6:0]         count;
	} list_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [4:0]         operation = '0;
	logic [5:0]         position = '0;
	logic signed [31:0] value = '0;
	logic               busy;
	logic               done;
	logic [2:0]         status;
	logic signed [31:0] value_out;
	logic [5:0]         position_out;
	logic [6:0]         count_out;

	logic signed [31:0] list_vals[$];
	list_result_t       pending_results[$];
	int                 error_count = 0;
	int                 items_sent = 0;
	int                 results_seen = 0;
	int                 peak_fill = 0;
	int                 full_hits = 0;
	int                 cycle_count = 0;
	int                 sender_idle_pct = 0;

	circular_list_engine_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.operation   (operation),
		.position    (position),
		.value       (value),
		.busy        (busy),
		.done        (done),
		.status      (status),
		.value_out   (value_out),
		.position_out(position_out),
		.count_out   (count_out)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// apply one command to the tracked list and return its result
	function automatic list_result_t apply_list_op(logic [4:0] op, logic [5:0] pos,
			logic signed [31:0] val);
		list_result_t r;
		int n;
		logic signed [31:0] v;
		r = '0;
		n = list_vals.size();
		r.status = cle_pkg::ST_OK;
		if (op > cle_pkg::OP_CLEAR) begin
			r.status = cle_pkg::ST_NOACTION;
		end else if (op == cle_pkg::OP_ADD_FRONT || op == cle_pkg::OP_ADD_BACK) begin
			if (n >= LIST_DEPTH) r.status = cle_pkg::ST_FULL;
			else if (op == cle_pkg::OP_ADD_FRONT) list_vals.push_front(val);
			else list_vals.push_back(val);
		end else if (n == 0) begin
			r.status = cle_pkg::ST_EMPTY;
		end else begin
			case (op)
				cle_pkg::OP_ADD_AT: begin
					if (pos >= n) r.status = cle_pkg::ST_NOTFOUND;
					else if (n >= LIST_DEPTH) r.status = cle_pkg::ST_FULL;
					else list_vals.insert(pos, val);
				end
				cle_pkg::OP_DEL_FRONT: void'(list_vals.pop_front());
				cle_pkg::OP_DEL_BACK:  void'(list_vals.pop_back());
				cle_pkg::OP_RD_FRONT:  r.value = list_vals[0];
				cle_pkg::OP_RD_BACK:   r.value = list_vals[n-1];
				cle_pkg::OP_DEL_AT, cle_pkg::OP_RD_AT, cle_pkg::OP_UPDATE,
				cle_pkg::OP_TO_FRONT, cle_pkg::OP_TO_BACK: begin
					if (pos >= n) begin
						r.status = cle_pkg::ST_NOTFOUND;
					end else begin
						v = list_vals[pos];
						case (op)
							cle_pkg::OP_DEL_AT: list_vals.delete(pos);
							cle_pkg::OP_RD_AT:  r.value = v;
							cle_pkg::OP_UPDATE: list_vals[pos] = val;
							cle_pkg::OP_TO_FRONT: begin
								if (pos == 0) r.status = cle_pkg::ST_NOACTION;
								else begin
									list_vals.delete(pos);
									list_vals.push_front(v);
								end
							end
							default: begin
								// head to back rotates; tail stays put
								list_vals.delete(pos);
								list_vals.push_back(v);
							end
						endcase
					end
				end
				cle_pkg::OP_FIND: begin
					r.status = cle_pkg::ST_NOTFOUND;
					for (int i = 0; i < n; i++) begin
						if (list_vals[i] == val) begin
							r.status = cle_pkg::ST_OK;
							r.value = val;
							r.position = 6'(i);
							break;
						end
					end
				end
				cle_pkg::OP_MIN, cle_pkg::OP_MAX: begin
					r.value = list_vals[0];
					for (int i = 1; i < n; i++) begin
						if (op == cle_pkg::OP_MIN ? list_vals[i] < r.value :
								list_vals[i] > r.value) begin
							r.value = list_vals[i];
							r.position = 6'(i);
						end
					end
				end
				cle_pkg::OP_CLEAR: list_vals.delete();
				default: ;
			endcase
		end
		if (r.status != cle_pkg::ST_OK) begin
			r.value = '0;
			r.position = '0;
		end
		if (r.status == cle_pkg::ST_FULL) full_hits++;
		r.count = 7'(list_vals.size());
		if (list_vals.size() > peak_fill) peak_fill = list_vals.size();
		return r;
	endfunction

	task automatic send_command(logic [4:0] op, logic [5:0] pos, logic signed [31:0] val);
		if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct)
			repeat ($urandom_range(1, 6)) @(negedge clk);
		start = 1'b1;
		operation = op;
		position = pos;
		value = val;
		do @(posedge clk); while (busy);
		pending_results.push_back(apply_list_op(op, pos, val));
		items_sent++;
		@(negedge clk);
		start = 1'b0;
	endtask

	always @(posedge clk) begin
		list_result_t exp_r;
		if (arst_n && done) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: result with no command outstanding", $time);
				error_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.status) begin
					$display("%0t: status expected %0d actual %0d", $time, exp_r.status, status);
					error_count++;
				end
				if (value_out !== exp_r.value) begin
					$display("%0t: value_out expected %0d actual %0d", $time,
						exp_r.value, value_out);
					error_count++;
				end
				if (position_out !== exp_r.position) begin
					$display("%0t: position_out expected %0d actual %0d", $time,
						exp_r.position, position_out);
					error_count++;
				end
				if (count_out !== exp_r.count) begin
					$display("%0t: count_out expected %0d actual %0d", $time,
						exp_r.count, count_out);
					error_count++;
				end
			end
		end
	end

	task automatic test_corner_cases();
		// empty list first: everything but the adds and the invalid code reports empty
		send_command(cle_pkg::OP_RD_FRONT, 6'd0, 32'sd0);
		send_command(cle_pkg::OP_SIZE, 6'd0, 32'sd0);
		send_command(cle_pkg::OP_CLEAR, 6'd0, 32'sd0);
		send_command(5'd31, 6'd63, 32'sd0);
		send_command(cle_pkg::OP_ADD_BACK, 6'd0, 32'sh7fffffff);
		send_command(cle_pkg::OP_ADD_FRONT, 6'd0, 32'sh80000000);
		send_command(cle_pkg::OP_ADD_BACK, 6'd0, -32'sd1);
		send_command(cle_pkg::OP_ADD_AT, 6'd1, 32'sd0);
		send_command(cle_pkg::OP_ADD_AT, 6'd4, 32'sd5);
		send_command(cle_pkg::OP_RD_AT, 6'd2, 32'sd0);
		send_command(cle_pkg::OP_UPDATE, 6'd1, 32'sh7fffffff);
		send_command(cle_pkg::OP_FIND, 6'd0, 32'sh7fffffff);
		send_command(cle_pkg::OP_FIND, 6'd0, 32'sd12345);
		send_command(cle_pkg::OP_MIN, 6'd0, 32'sd0);
		send_command(cle_pkg::OP_MAX, 6'd0, 32'sd0);
		send_command(cle_pkg::OP_TO_FRONT, 6'd0, 32'sd0);
		send_command(cle_pkg::OP_TO_FRONT, 6'd2, 32'sd0);
		send_command(cle_pkg::OP_TO_BACK, 6'd0, 32'sd0);
		send_command(cle_pkg::OP_TO_BACK, 6'd3, 32'sd0);
		send_command(cle_pkg::OP_DEL_AT, 6'd63, 32'sd0);
		send_command(cle_pkg::OP_RD_BACK, 6'd0, 32'sd0);
		send_command(cle_pkg::OP_DEL_FRONT, 6'd0, 32'sd0);
		send_command(cle_pkg::OP_DEL_BACK, 6'd0, 32'sd0);
		send_command(cle_pkg::OP_SIZE, 6'd0, 32'sd0);
		send_command(cle_pkg::OP_CLEAR, 6'd0, 32'sd0);
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return 32'sh80000000;
			1:       return 32'sh7fffffff;
			2, 3, 4: return $urandom_range(0, 7) - 3;   // narrow pool forces hits and ties
			default: return $urandom;
		endcase
	endfunction

	task automatic test_random_traffic(int idle_pct, int num_items);
		int n;
		int r;
		bit growing;
		logic [4:0] op;
		logic [5:0] pos;
		sender_idle_pct = idle_pct;
		for (int k = 0; k < num_items; k++) begin
			n = list_vals.size();
			growing = (k % 240) < 150;
			r = $urandom_range(0, 99);
			if (r < 3) op = 5'($urandom_range(17, 31));
			else if (r < (growing ? 55 : 15))
				op = 5'($urandom_range(cle_pkg::OP_ADD_FRONT, cle_pkg::OP_ADD_AT));
			else if (r < (growing ? 65 : 55))
				op = 5'($urandom_range(cle_pkg::OP_DEL_FRONT, cle_pkg::OP_DEL_AT));
			else op = 5'($urandom_range(cle_pkg::OP_RD_FRONT, cle_pkg::OP_CLEAR));
			// hold clear back so the list gets a chance to fill
			if (op == cle_pkg::OP_CLEAR && $urandom_range(0, 3) != 0) op = cle_pkg::OP_SIZE;
			if (n > 0 && $urandom_range(0, 4) != 0) pos = 6'($urandom_range(0, n - 1));
			else pos = 6'($urandom_range(0, 63));
			if (op == cle_pkg::OP_FIND && n > 0 && $urandom_range(0, 1) == 1)
				send_command(op, pos, list_vals[$urandom_range(0, n - 1)]);
			else
				send_command(op, pos, pick_value());
		end
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_corner_cases();
		test_random_traffic(22, 500);
		test_random_traffic(56, 500);
		test_random_traffic(0, 500);
		while (pending_results.size() > 0) @(posedge clk);
		repeat (250) @(posedge clk);
		$display("Sent %0d commands, checked %0d results", items_sent, results_seen);
		$display("Peak fill %0d of %0d entries, %0d adds refused as full",
			peak_fill, LIST_DEPTH, full_hits);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
